// ----- src/bq_pkg.sv -----
// Shared constants, codes and command types for the biquad filter.
package bq_pkg;

    // Default widths of the sample, coefficient and delay state words.
    localparam int DEF_SAMPLE_WIDTH = 24;
    localparam int DEF_COEF_WIDTH   = 32;
    localparam int DEF_STATE_WIDTH  = 48;

    // Integer bits of a coefficient (Q8.x) and extra fraction bits of the states.
    localparam int COEF_INT_BITS = 8;
    localparam int GUARD_BITS    = 16;

    // Coefficient register file.
    localparam int CFG_INDEX_WIDTH = 3;

    // Coefficient codes, shared by the register index and the multiplier select.
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        COEF_B0 = 3'd0,
        COEF_B1 = 3'd1,
        COEF_B2 = 3'd2,
        COEF_A1 = 3'd3,
        COEF_A2 = 3'd4
    } t_coef_idx;

    // Accumulator operand select.
    typedef enum logic [1:0] {
        OPND_P  = 2'd0,
        OPND_D1 = 2'd1,
        OPND_D2 = 2'd2
    } t_opnd;

    // Command word from the controller to the datapath.
    typedef struct packed {
        logic      load_x;
        logic      mul_en;
        t_coef_idx mul_coef;
        logic      mul_use_y;
        logic      acc_en;
        logic      acc_keep;
        logic      acc_rnd_y;
        t_opnd     acc_opnd;
        logic      acc_sub;
        logic      y_load;
        logic      d1_load;
        logic      d2_load;
        logic      out_load;
    } t_bq_cmd;

endpackage

// ----- src/biquad_tdf2_filter.sv -----
// Top level of the second-order IIR filter in transposed direct form II.
//
// Input channel: i_in_valid / o_in_stall carry one word, a signed sample
// (i_sample_in) and a flag (i_clear_history) that zeroes both delay states
// before the sample is filtered. A word is taken at a clock edge with valid
// high and stall low.
// Output channel: o_out_valid / i_out_stall carry one word per input word,
// the rounded and saturated sample and a flag set when the output or a
// delay state saturated.
// Coefficients b0, b1, b2, a1, a2 (indexes 0 to 4) are written through
// i_cfg_we / i_cfg_index / i_cfg_data; the user must do so only while the
// filter is idle, as the block itself does not enforce it.
// One shared multiplier takes the five products in turn; words are not
// overlapped, and the next word is accepted in the cycle that the current
// result is written to the output register.
// When the receiver stalls, the output word holds; the filter takes the
// word in progress up to its last step and waits with its input stalled.
// Reset loads the pass-through coefficients (b0 = 1.0, others zero), clears
// both delay states and empties the output register.
module biquad_tdf2_filter
    import bq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = DEF_COEF_WIDTH,
    parameter int STATE_WIDTH  = DEF_STATE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0]     i_cfg_index,
    input  logic [COEF_WIDTH-1:0]          i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    input  logic                           i_clear_history,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    output logic                           o_clipped
);

    t_bq_cmd cmd;

    // Sequencer.
    bq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // Arithmetic and storage.
    bq_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH),
        .STATE_WIDTH  (STATE_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_sample_in     (i_sample_in),
        .i_clear_history (i_clear_history),
        .i_cmd           (cmd),
        .o_sample_out    (o_sample_out),
        .o_clipped       (o_clipped)
    );

endmodule

// ----- src/bq_datapath.sv -----
// Datapath of the biquad filter: coefficients, multiplier, accumulator and states.
module bq_datapath
    import bq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = DEF_COEF_WIDTH,
    parameter int STATE_WIDTH  = DEF_STATE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0]     i_cfg_index,
    input  logic [COEF_WIDTH-1:0]          i_cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    input  logic                           i_clear_history,
    input  t_bq_cmd                        i_cmd,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    output logic                           o_clipped
);

    localparam int CF   = COEF_WIDTH - COEF_INT_BITS;
    localparam int PW   = COEF_WIDTH + SAMPLE_WIDTH;
    localparam int AW_P = PW + GUARD_BITS;
    localparam int AW_D = STATE_WIDTH + CF;
    localparam int AW   = ((AW_P > AW_D) ? AW_P : AW_D) + 3;
    localparam int YSH  = CF + GUARD_BITS;

    localparam logic signed [AW-1:0] RND_Y = AW'(1) << (YSH - 1);
    localparam logic signed [AW-1:0] RND_S = AW'(1) << (CF - 1);
    localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) << CF;
    localparam logic [SAMPLE_WIDTH-1:0] Y_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] Y_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic [STATE_WIDTH-1:0]  S_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
    localparam logic [STATE_WIDTH-1:0]  S_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};

    logic signed [COEF_WIDTH-1:0]   r_b0, r_b1, r_b2, r_a1, r_a2;
    logic signed [SAMPLE_WIDTH-1:0] r_x, r_y, r_out;
    logic signed [PW-1:0]           r_p, n_p;
    logic signed [AW-1:0]           r_acc, n_acc;
    logic signed [STATE_WIDTH-1:0]  r_d1, r_d2;
    logic                           r_clip, r_out_clip;

    logic signed [COEF_WIDTH-1:0]   mul_a;
    logic signed [SAMPLE_WIDTH-1:0] mul_b;
    logic signed [AW-1:0]           acc_base, acc_opnd;
    logic [AW-1:YSH+SAMPLE_WIDTH-1] y_hi;
    logic [AW-1:CF+STATE_WIDTH-1]   s_hi;
    logic                           y_fit, s_fit;
    logic [SAMPLE_WIDTH-1:0]        y_sat;
    logic [STATE_WIDTH-1:0]         s_sat;

    // Multiplier operand selection and the product.
    always_comb begin
        unique case (i_cmd.mul_coef)
            COEF_B0: mul_a = r_b0;
            COEF_B1: mul_a = r_b1;
            COEF_B2: mul_a = r_b2;
            COEF_A1: mul_a = r_a1;
            COEF_A2: mul_a = r_a2;
            default: mul_a = r_b0;
        endcase
        mul_b = i_cmd.mul_use_y ? r_y : r_x;
        n_p   = PW'(mul_a) * PW'(mul_b);
    end

    // Accumulator: a base (running sum or rounding constant) plus or minus one operand.
    always_comb begin
        case (i_cmd.acc_opnd)
            OPND_P:  acc_opnd = AW'(r_p) <<< GUARD_BITS;
            OPND_D1: acc_opnd = AW'(r_d1) <<< CF;
            OPND_D2: acc_opnd = AW'(r_d2) <<< CF;
            default: acc_opnd = '0;
        endcase
        if (i_cmd.acc_keep) begin
            acc_base = r_acc;
        end else begin
            acc_base = i_cmd.acc_rnd_y ? RND_Y : RND_S;
        end
        n_acc = i_cmd.acc_sub ? (acc_base - acc_opnd) : (acc_base + acc_opnd);
    end

    // Shift and saturate the rounded sum to the sample and state ranges.
    always_comb begin
        y_hi  = r_acc[AW-1:YSH+SAMPLE_WIDTH-1];
        y_fit = (&y_hi) | ~(|y_hi);
        y_sat = y_fit ? r_acc[YSH+SAMPLE_WIDTH-1:YSH] : (r_acc[AW-1] ? Y_MIN : Y_MAX);
        s_hi  = r_acc[AW-1:CF+STATE_WIDTH-1];
        s_fit = (&s_hi) | ~(|s_hi);
        s_sat = s_fit ? r_acc[CF+STATE_WIDTH-1:CF] : (r_acc[AW-1] ? S_MIN : S_MAX);
    end

    // Coefficient registers and delay states.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= COEF_ONE;
            r_b1 <= '0;
            r_b2 <= '0;
            r_a1 <= '0;
            r_a2 <= '0;
            r_d1 <= '0;
            r_d2 <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_coef_idx'(i_cfg_index))
                    COEF_B0: r_b0 <= i_cfg_data;
                    COEF_B1: r_b1 <= i_cfg_data;
                    COEF_B2: r_b2 <= i_cfg_data;
                    COEF_A1: r_a1 <= i_cfg_data;
                    COEF_A2: r_a2 <= i_cfg_data;
                    default: ;
                endcase
            end
            // A clear on the new word wins over the last state write of the old one.
            if (i_cmd.load_x && i_clear_history) begin
                r_d1 <= '0;
                r_d2 <= '0;
            end else begin
                if (i_cmd.d1_load) begin
                    r_d1 <= s_sat;
                end
                if (i_cmd.d2_load) begin
                    r_d2 <= s_sat;
                end
            end
        end
    end

    // Working registers and the output word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) begin
            r_x    <= i_sample_in;
            r_clip <= 1'b0;
        end
        if (i_cmd.mul_en) begin
            r_p <= n_p;
        end
        if (i_cmd.acc_en) begin
            r_acc <= n_acc;
        end
        if (i_cmd.y_load) begin
            r_y    <= y_sat;
            r_clip <= r_clip | ~y_fit;
        end
        if (i_cmd.d1_load) begin
            r_clip <= r_clip | ~s_fit;
        end
        if (i_cmd.out_load) begin
            r_out      <= r_y;
            r_out_clip <= r_clip | ~s_fit;
        end
    end

    assign o_sample_out = r_out;
    assign o_clipped    = r_out_clip;

endmodule

// ----- src/bq_ctrl.sv -----
// Sequencer of the biquad filter: steps the shared multiplier and accumulator.
module bq_ctrl
    import bq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_bq_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_B0,
        S_ACC_B0,
        S_OUT_Y,
        S_ACC_B1,
        S_SUB_A1,
        S_ST_N1,
        S_SUB_A2,
        S_ST_N2
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   out_free, in_accept;

    // The output register can take a new word when empty or being drained.
    assign out_free   = ~r_out_valid | ~i_out_stall;
    assign o_in_stall = ~((r_state == S_IDLE) || ((r_state == S_ST_N2) && out_free));
    assign in_accept  = i_in_valid & ~o_in_stall;

    // Command decode and next state.
    always_comb begin
        o_cmd           = '0;
        o_cmd.mul_coef  = COEF_B0;
        o_cmd.acc_opnd  = OPND_P;
        n_state         = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load_x = in_accept;
                if (in_accept) begin
                    n_state = S_MUL_B0;
                end
            end
            S_MUL_B0: begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_coef  = COEF_B0;
                o_cmd.acc_en    = 1'b1;
                o_cmd.acc_rnd_y = 1'b1;
                o_cmd.acc_opnd  = OPND_D1;
                n_state         = S_ACC_B0;
            end
            S_ACC_B0: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_coef = COEF_B1;
                o_cmd.acc_en   = 1'b1;
                o_cmd.acc_keep = 1'b1;
                n_state        = S_OUT_Y;
            end
            S_OUT_Y: begin
                o_cmd.y_load   = 1'b1;
                o_cmd.acc_en   = 1'b1;
                o_cmd.acc_opnd = OPND_D2;
                n_state        = S_ACC_B1;
            end
            S_ACC_B1: begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_coef  = COEF_A1;
                o_cmd.mul_use_y = 1'b1;
                o_cmd.acc_en    = 1'b1;
                o_cmd.acc_keep  = 1'b1;
                n_state         = S_SUB_A1;
            end
            S_SUB_A1: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_coef = COEF_B2;
                o_cmd.acc_en   = 1'b1;
                o_cmd.acc_keep = 1'b1;
                o_cmd.acc_sub  = 1'b1;
                n_state        = S_ST_N1;
            end
            S_ST_N1: begin
                o_cmd.d1_load   = 1'b1;
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_coef  = COEF_A2;
                o_cmd.mul_use_y = 1'b1;
                o_cmd.acc_en    = 1'b1;
                n_state         = S_SUB_A2;
            end
            S_SUB_A2: begin
                o_cmd.acc_en   = 1'b1;
                o_cmd.acc_keep = 1'b1;
                o_cmd.acc_sub  = 1'b1;
                n_state        = S_ST_N2;
            end
            S_ST_N2: begin
                o_cmd.d2_load  = out_free;
                o_cmd.out_load = out_free;
                o_cmd.load_x   = in_accept;
                if (out_free) begin
                    n_state = in_accept ? S_MUL_B0 : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    // A pending word that the receiver holds off keeps the last step waiting.
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ST_N2) && r_out_valid && i_out_stall |=> (r_state == S_ST_N2))
        else $error("final step advanced over a stalled output word");

    // New words enter only when the sequencer is free or finishing.
    a_accept_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |-> ((r_state == S_IDLE) || (r_state == S_ST_N2)))
        else $error("input word accepted in the middle of a computation");

    // An accepted word always starts the multiply sequence.
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_MUL_B0))
        else $error("accepted word did not start the sequence");

    // The output word is only loaded from the final step.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> ((r_state == S_ST_N2) && out_free))
        else $error("output register loaded outside the final step");

endmodule

// ----- test/tb.sv -----
// Testbench for the transposed direct form II biquad filter: bit-exact prediction and checking.
module tb
    import bq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW         = DEF_SAMPLE_WIDTH;
    localparam int CW         = DEF_COEF_WIDTH;
    localparam int STW        = DEF_STATE_WIDTH;
    localparam int COEF_FRAC  = CW - COEF_INT_BITS;
    localparam int NUM_COEFS  = 5;
    localparam int DRAIN_WAIT = 10;
    localparam int IDLE_LIMIT = 5000;
    localparam int PHASE_WORDS = 106;

    localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic [CW-1:0]        COEF_MAX   = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0]        COEF_MIN   = {1'b1, {(CW-1){1'b0}}};

    typedef logic signed [127:0] acc_t;

    // Holds the filter coefficients and delay states, predicts each output word
    // and checks the words that come out of the filter.
    class biquad_scoreboard;
        typedef struct {
            logic signed [SW-1:0] sample;
            logic                 clipped;
        } out_word_t;

        logic signed [CW-1:0] coef [NUM_COEFS];
        acc_t                 delay_one;
        acc_t                 delay_two;
        bit                   clip_seen;
        out_word_t            expected_outputs [$];
        int                   errors;
        int                   samples_taken;
        int                   clears_taken;
        int                   outputs_checked;
        int                   outputs_clipped;

        function new();
            coef[COEF_B0] = 1 <<< COEF_FRAC;
            coef[COEF_B1] = '0;
            coef[COEF_B2] = '0;
            coef[COEF_A1] = '0;
            coef[COEF_A2] = '0;
            delay_one = '0;
            delay_two = '0;
            errors = 0;
            samples_taken = 0;
            clears_taken = 0;
            outputs_checked = 0;
            outputs_clipped = 0;
        endfunction

        function void set_coef(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CW-1:0] value);
            if (idx < NUM_COEFS) begin
                coef[idx] = value;
            end
        endfunction

        // Round half up, then shift right arithmetically.
        function acc_t round_shift(acc_t v, int n);
            return (v + (acc_t'(1) <<< (n - 1))) >>> n;
        endfunction

        function acc_t saturate(acc_t v, int w);
            acc_t hi_lim;
            acc_t lo_lim;
            hi_lim = (acc_t'(1) <<< (w - 1)) - 1;
            lo_lim = -(acc_t'(1) <<< (w - 1));
            if (v > hi_lim) begin
                clip_seen = 1'b1;
                return hi_lim;
            end
            if (v < lo_lim) begin
                clip_seen = 1'b1;
                return lo_lim;
            end
            return v;
        endfunction

        // Filters one accepted sample and queues the word it must produce.
        function void take_sample(logic signed [SW-1:0] sample_in, logic clear_history);
            acc_t      x;
            acc_t      y;
            acc_t      sum;
            acc_t      next_one;
            acc_t      next_two;
            out_word_t word;
            x = sample_in;
            samples_taken++;
            if (clear_history) begin
                clears_taken++;
                delay_one = '0;
                delay_two = '0;
            end
            clip_seen = 1'b0;

            // Output: b0*x plus the first state, state bits aligned to the product.
            sum = (delay_one <<< COEF_FRAC) + ((coef[COEF_B0] * x) <<< GUARD_BITS);
            y = saturate(round_shift(sum, COEF_FRAC + GUARD_BITS), SW);

            // New states use the rounded and saturated output in the feedback.
            sum = ((coef[COEF_B1] * x - coef[COEF_A1] * y) <<< GUARD_BITS)
                + (delay_two <<< COEF_FRAC);
            next_one = saturate(round_shift(sum, COEF_FRAC), STW);
            sum = (coef[COEF_B2] * x - coef[COEF_A2] * y) <<< GUARD_BITS;
            next_two = saturate(round_shift(sum, COEF_FRAC), STW);

            delay_one = next_one;
            delay_two = next_two;
            word.sample  = y[SW-1:0];
            word.clipped = clip_seen;
            expected_outputs.push_back(word);
        endfunction

        function void check_output(logic signed [SW-1:0] sample_out, logic clipped);
            out_word_t word;
            if (expected_outputs.size() == 0) begin
                $display("%0t ns: output word with none expected: sample %0d clipped %0b",
                         $time, sample_out, clipped);
                errors++;
                return;
            end
            word = expected_outputs.pop_front();
            outputs_checked++;
            if (word.clipped) begin
                outputs_clipped++;
            end
            if (sample_out !== word.sample) begin
                $display("%0t ns: sample_out mismatch: expected %0d, actual %0d",
                         $time, word.sample, sample_out);
                errors++;
            end
            if (clipped !== word.clipped) begin
                $display("%0t ns: clipped mismatch: expected %0b, actual %0b",
                         $time, word.clipped, clipped);
                errors++;
            end
        endfunction

        function int pending();
            return expected_outputs.size();
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index = '0;
    logic [CW-1:0]              i_cfg_data = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic signed [SW-1:0]       i_sample_in = '0;
    logic                       i_clear_history = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic signed [SW-1:0]       o_sample_out;
    logic                       o_clipped;

    biquad_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int coef_sets = 0;
    int idle_cycles = 0;

    biquad_tdf2_filter DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample_in    (i_sample_in),
        .i_clear_history(i_clear_history),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sample_out   (o_sample_out),
        .o_clipped      (o_clipped)
    );

    always #5 i_clk = ~i_clk;

    // Receiver back-pressure, changed on the falling edge.
    always @(negedge i_clk) begin
        i_out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // Both channels are observed on the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                sb.take_sample(i_sample_in, i_clear_history);
            end
            if (o_out_valid && !i_out_stall) begin
                sb.check_output(o_sample_out, o_clipped);
            end
        end
    end

    // Watchdog on cycles with no word moving on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t ns: no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Offers one word, after a random gap, and returns at the falling edge
    // after it was taken.
    task automatic send_word(input logic signed [SW-1:0] sample, input logic clear);
        while ((send_idle_pct != 0) && ($urandom_range(99) < send_idle_pct)) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_sample_in     <= sample;
        i_clear_history <= clear;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // Holds the input idle until every expected word has come out.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [CW-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        sb.set_coef(idx, value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_coefs(input logic [CW-1:0] b0, input logic [CW-1:0] b1,
                              input logic [CW-1:0] b2, input logic [CW-1:0] a1,
                              input logic [CW-1:0] a2);
        drain();
        write_reg(COEF_B0, b0);
        write_reg(COEF_B1, b1);
        write_reg(COEF_B2, b2);
        write_reg(COEF_A1, a1);
        write_reg(COEF_A2, a2);
        coef_sets++;
    endtask

    // Mostly full-scale random audio, with small values and the rails mixed in.
    function automatic logic signed [SW-1:0] random_sample();
        case ($urandom_range(9))
            6, 7: return SW'($urandom_range(512) - 256);
            8: return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
            9: return $urandom_range(1) ? SAMPLE_MAX - SW'($urandom_range(4095))
                                        : SAMPLE_MIN + SW'($urandom_range(4095));
            default: return SW'($urandom);
        endcase
    endfunction

    // Picks a coefficient set of the given kind: a fixed low-pass, a random
    // stable filter, fully random words, or a high-gain resonator.
    task automatic load_kind(input int kind);
        int a1v;
        int a2v;
        int lim;
        case (kind)
            0: load_coefs(32'd65700, 32'd131400, 32'd65700, -32'sd30450647, 32'sd13941867);
            1: begin
                a2v = $urandom_range(2 * 15938355) - 15938355;
                lim = ((16777216 + a2v) / 50) * 49;
                a1v = $urandom_range(2 * lim) - lim;
                load_coefs($urandom_range(1 << 27) - (1 << 26),
                           $urandom_range(1 << 27) - (1 << 26),
                           $urandom_range(1 << 27) - (1 << 26), a1v, a2v);
            end
            2: load_coefs($urandom, $urandom, $urandom, $urandom, $urandom);
            default: load_coefs($urandom, $urandom, $urandom, -32'sd33386660, 32'sd16760439);
        endcase
    endtask

    initial begin
        int mode;
        int kind;
        int clear_pct;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Writes to indexes past the last coefficient must leave the reset
        // pass-through filter untouched.
        for (int i = NUM_COEFS; i < 2 ** CFG_INDEX_WIDTH; i++) begin
            write_reg(i[CFG_INDEX_WIDTH-1:0], $urandom);
        end
        send_word(SAMPLE_MAX, 1'b0);
        send_word(SAMPLE_MIN, 1'b0);
        send_word('0, 1'b0);
        send_word(SW'(1), 1'b0);
        send_word(-SW'(1), 1'b0);

        // All coefficients at the positive rail: output and states saturate.
        load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        send_word(SAMPLE_MAX, 1'b1);
        send_word(SAMPLE_MIN, 1'b0);
        send_word(SAMPLE_MAX, 1'b0);
        send_word(SW'(1), 1'b0);

        // All coefficients at the negative rail.
        load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        send_word(SAMPLE_MIN, 1'b1);
        send_word(SAMPLE_MAX, 1'b0);
        send_word(-SW'(1), 1'b0);
        send_word('0, 1'b1);

        // Low-pass step response, then a history clear in mid-stream.
        load_kind(0);
        send_word(SAMPLE_MAX, 1'b1);
        repeat (4) send_word(SAMPLE_MAX, 1'b0);
        send_word(SAMPLE_MIN, 1'b1);

        // Random phases: every idling mode meets two coefficient kinds.
        for (int ph = 0; ph < 8; ph++) begin
            mode = ph % 4;
            kind = (ph + ph / 4) % 4;
            load_kind(kind);
            send_idle_pct  = (mode == 1) ? 86 : (mode == 3) ? 17 : 0;
            recv_stall_pct = (mode == 2) ? 86 : (mode == 3) ? 17 : 0;
            clear_pct = (kind == 2) ? 25 : 4;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (n == PHASE_WORDS / 2) begin
                    drain();
                end
                send_word(random_sample(), $urandom_range(99) < clear_pct);
            end
            drain();
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end

        drain();
        repeat (20) @(negedge i_clk);
        $display("Filtered %0d samples (%0d with history clear) under %0d coefficient sets.",
                 sb.samples_taken, sb.clears_taken, coef_sets + 1);
        $display("Checked %0d output words, %0d of them clipped.",
                 sb.outputs_checked, sb.outputs_clipped);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
